### rtl/tlrg_pkg.sv
// ----------------------------------------------------------------------------
// tlrg_pkg
// Shared widths, register map, reset values and sideband types of the
// thin-lens primary ray generator.
// ----------------------------------------------------------------------------
package tlrg_pkg;

    // default pixel index width
    localparam int COORD_BITS_DEF = 12;

    // configuration register widths
    localparam int BASIS_W = 48;
    localparam int EYE_W   = 60;
    localparam int RAD_W   = 19;
    localparam int PSC_W   = 16;
    localparam int FOC_W   = 19;
    localparam int ISZ_W   = 24;

    // apb port
    localparam int CFG_DW    = 64;
    localparam int CFG_AW    = 6;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_U   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_V   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EYE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENS_RAD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_SCL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_SIZE  = 3'd7;

    // reset values
    localparam logic [BASIS_W-1:0] RST_BASIS_U = 48'h0000_0000_4000;
    localparam logic [BASIS_W-1:0] RST_BASIS_V = 48'h0000_4000_0000;
    localparam logic [BASIS_W-1:0] RST_BASIS_W = 48'h4000_0000_0000;
    localparam logic [EYE_W-1:0]   RST_EYE     = '0;
    localparam logic [RAD_W-1:0]   RST_RAD     = 19'd256;
    localparam logic [PSC_W-1:0]   RST_PSC     = 16'd614;
    localparam logic [FOC_W-1:0]   RST_FOC     = 19'd19200;
    localparam logic [ISZ_W-1:0]   RST_ISZ     = '0;

    // field and datapath widths
    localparam int SMP_W  = 16;
    localparam int DSK_W  = 16;
    localparam int ORG_W  = 20;
    localparam int DIR_W  = 16;
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;
    localparam int NUM_W  = 46;
    localparam int QUO_W  = 15;
    localparam logic [QUO_W-1:0] Q_ONE = 15'd16384;

    // width of the unnormalized direction for a given coordinate width
    function automatic int dir_width(input int cb);
        return cb + 42;
    endfunction

    // signed q1.14 component k of a packed basis vector
    function automatic logic signed [15:0] comp16(input logic [BASIS_W-1:0] v,
                                                  input int k);
        return signed'(v[16*k +: 16]);
    endfunction

    // words carried alongside the direction math
    typedef struct packed {
        logic [2:0]             neg;
        logic                   zero;
        logic [2:0][ORG_W-1:0]  org;
    } t_side;

    typedef struct packed {
        t_side                  sd;
        logic [2:0][MAG_W-1:0]  mag;
    } t_nside;

endpackage

### rtl/tlrg_front.sv
// ----------------------------------------------------------------------------
// tlrg_front
// Pixel and lens points, ray origin and unnormalized direction in six
// register stages.
// ----------------------------------------------------------------------------
module tlrg_front #(
    parameter int COORD_BITS = 12,
    parameter int DW         = 54
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [COORD_BITS-1:0]           i_col,
    input  logic [COORD_BITS-1:0]           i_row,
    input  logic [tlrg_pkg::SMP_W-1:0]      i_sample_x,
    input  logic [tlrg_pkg::SMP_W-1:0]      i_sample_y,
    input  logic signed [tlrg_pkg::DSK_W-1:0] i_disk_x,
    input  logic signed [tlrg_pkg::DSK_W-1:0] i_disk_y,
    input  logic [tlrg_pkg::BASIS_W-1:0]    i_basis_u,
    input  logic [tlrg_pkg::BASIS_W-1:0]    i_basis_v,
    input  logic [tlrg_pkg::BASIS_W-1:0]    i_basis_w,
    input  logic [tlrg_pkg::EYE_W-1:0]      i_eye,
    input  logic [tlrg_pkg::RAD_W-1:0]      i_lens_radius,
    input  logic [tlrg_pkg::PSC_W-1:0]      i_plane_scale,
    input  logic [tlrg_pkg::FOC_W-1:0]      i_focal_dist,
    input  logic [tlrg_pkg::ISZ_W-1:0]      i_image_size,
    output logic                            o_valid,
    output logic [2:0][tlrg_pkg::ORG_W-1:0] o_org,
    output logic [2:0][DW-1:0]              o_mag,
    output logic [2:0]                      o_neg
);
    import tlrg_pkg::*;

    localparam int CXW = COORD_BITS + 18;
    localparam int PXW = CXW + 17;
    localparam int LPW = 36;
    localparam int LXW = 30;
    localparam int AXW = COORD_BITS + 24;
    localparam int AUW = AXW + 16;
    localparam int LUW = LXW + 16;
    localparam int FWW = 44;
    localparam int OW  = 49;
    localparam int IW  = (2 * COORD_BITS > ISZ_W) ? 2 * COORD_BITS : ISZ_W;

    localparam logic signed [PXW-1:0] PX_RND  = PXW'(2048);
    localparam logic signed [LPW-1:0] LX_RND  = LPW'(32);
    localparam logic signed [OW-1:0]  ORG_RND = OW'(2097152);
    localparam logic signed [OW-1:0]  ORG_MAX = OW'(524287);
    localparam logic signed [OW-1:0]  ORG_MIN = -OW'(524288);

    // image width and height
    logic [IW-1:0]         isz_ext;
    logic [COORD_BITS-1:0] wid;
    logic [COORD_BITS-1:0] hei;
    assign isz_ext = IW'(i_image_size);
    assign wid     = isz_ext[COORD_BITS-1:0];
    assign hei     = isz_ext[2*COORD_BITS-1:COORD_BITS];

    // stage 1: centred pixel point
    logic                  r1_v;
    logic signed [CXW-1:0] r1_cx, r1_cy;
    logic signed [DSK_W-1:0] r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_valid;
        r1_cx <= (CXW'(i_col) << 16) - (CXW'(wid) << 15) + CXW'(i_sample_x);
        r1_cy <= (CXW'(i_row) << 16) - (CXW'(hei) << 15) + CXW'(i_sample_y);
        r1_dx <= i_disk_x;
        r1_dy <= i_disk_y;
    end

    // stage 2: scale by plane scale and lens radius
    logic                  r2_v;
    logic signed [PXW-1:0] r2_pxp, r2_pyp;
    logic signed [LPW-1:0] r2_lxp, r2_lyp;
    logic signed [PSC_W:0] ps_s;
    logic signed [RAD_W:0] lr_s;
    assign ps_s = signed'({1'b0, i_plane_scale});
    assign lr_s = signed'({1'b0, i_lens_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_pxp <= PXW'(r1_cx) * PXW'(ps_s);
        r2_pyp <= PXW'(r1_cy) * PXW'(ps_s);
        r2_lxp <= LPW'(r1_dx) * LPW'(lr_s);
        r2_lyp <= LPW'(r1_dy) * LPW'(lr_s);
    end

    // stage 3: round to q.16 and form focal minus lens point
    logic                  r3_v;
    logic signed [LXW-1:0] r3_lx, r3_ly;
    logic signed [AXW-1:0] r3_ax, r3_ay;
    logic signed [PXW-1:0] px, py;
    logic signed [LPW-1:0] lx, ly;
    assign px = (r2_pxp + PX_RND) >>> 12;
    assign py = (r2_pyp + PX_RND) >>> 12;
    assign lx = (r2_lxp + LX_RND) >>> 6;
    assign ly = (r2_lyp + LX_RND) >>> 6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_lx <= LXW'(lx);
        r3_ly <= LXW'(ly);
        r3_ax <= AXW'(px) - AXW'(lx);
        r3_ay <= AXW'(py) - AXW'(ly);
    end

    // stage 4: products with the camera basis
    logic                  r4_v;
    logic signed [LUW-1:0] r4_lu [3];
    logic signed [LUW-1:0] r4_lv [3];
    logic signed [AUW-1:0] r4_au [3];
    logic signed [AUW-1:0] r4_av [3];
    logic signed [FWW-1:0] r4_fw [3];
    logic signed [FOC_W+8:0] f16;
    assign f16 = signed'({1'b0, i_focal_dist, 8'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        for (int k = 0; k < 3; k++) begin
            r4_lu[k] <= LUW'(r3_lx) * LUW'(comp16(i_basis_u, k));
            r4_lv[k] <= LUW'(r3_ly) * LUW'(comp16(i_basis_v, k));
            r4_au[k] <= AUW'(r3_ax) * AUW'(comp16(i_basis_u, k));
            r4_av[k] <= AUW'(r3_ay) * AUW'(comp16(i_basis_v, k));
            r4_fw[k] <= FWW'(f16) * FWW'(comp16(i_basis_w, k));
        end
    end

    // stage 5: sums per component
    logic                 r5_v;
    logic signed [OW-1:0] r5_os [3];
    logic signed [DW-1:0] r5_d  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r4_v;
        for (int k = 0; k < 3; k++) begin
            r5_os[k] <= (OW'(signed'(i_eye[20*k +: 20])) <<< 22) + OW'(r4_lu[k])
                        + OW'(r4_lv[k]) + ORG_RND;
            r5_d[k]  <= DW'(r4_au[k]) + DW'(r4_av[k]) - DW'(r4_fw[k]);
        end
    end

    // stage 6: saturate origin, split direction into sign and magnitude
    logic signed [OW-1:0] osh [3];
    always_comb begin
        for (int k = 0; k < 3; k++) osh[k] = r5_os[k] >>> 22;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r5_v;
        for (int k = 0; k < 3; k++) begin
            if (osh[k] > ORG_MAX)      o_org[k] <= ORG_MAX[ORG_W-1:0];
            else if (osh[k] < ORG_MIN) o_org[k] <= ORG_MIN[ORG_W-1:0];
            else                       o_org[k] <= osh[k][ORG_W-1:0];
            o_neg[k] <= r5_d[k][DW-1];
            o_mag[k] <= r5_d[k][DW-1] ? DW'(-r5_d[k]) : DW'(r5_d[k]);
        end
    end

endmodule

### rtl/tlrg_norm.sv
// ----------------------------------------------------------------------------
// tlrg_norm
// Scales the direction magnitudes so the largest sits in [2^29, 2^30) and
// forms the sum of squares, in five register stages.
// ----------------------------------------------------------------------------
module tlrg_norm #(
    parameter int DW = 54
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [2:0][DW-1:0]               i_mag,
    input  logic [2:0]                       i_neg,
    input  logic [2:0][tlrg_pkg::ORG_W-1:0]  i_org,
    output logic                             o_valid,
    output logic [tlrg_pkg::SQ_W-1:0]        o_sum,
    output tlrg_pkg::t_nside                 o_side
);
    import tlrg_pkg::*;

    localparam int PW = $clog2(DW);
    localparam logic [PW-1:0] TOP_POS = PW'(MAG_W - 1);

    // stage 1: largest magnitude
    logic                  r1_v;
    logic [2:0][DW-1:0]    r1_mag;
    logic [DW-1:0]         r1_mx;
    logic [2:0]            r1_neg;
    logic [2:0][ORG_W-1:0] r1_org;
    logic [DW-1:0]         mx01;
    assign mx01 = (i_mag[0] > i_mag[1]) ? i_mag[0] : i_mag[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_valid;
        r1_mag <= i_mag;
        r1_mx  <= (mx01 > i_mag[2]) ? mx01 : i_mag[2];
        r1_neg <= i_neg;
        r1_org <= i_org;
    end

    // stage 2: leading one position
    logic                  r2_v;
    logic [2:0][DW-1:0]    r2_mag;
    logic [PW-1:0]         r2_pos;
    t_side                 r2_sd;
    logic [PW-1:0]         pos;
    always_comb begin
        pos = '0;
        for (int i = 0; i < DW; i++) begin
            if (r1_mx[i]) pos = PW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_mag      <= r1_mag;
        r2_pos      <= pos;
        r2_sd.neg   <= r1_neg;
        r2_sd.zero  <= (r1_mx == '0);
        r2_sd.org   <= r1_org;
    end

    // stage 3: common shift of all magnitudes
    logic                    r3_v;
    logic [2:0][MAG_W-1:0]   r3_m;
    t_side                   r3_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        for (int k = 0; k < 3; k++) begin
            if (r2_pos >= TOP_POS) r3_m[k] <= MAG_W'(r2_mag[k] >> (r2_pos - TOP_POS));
            else                   r3_m[k] <= MAG_W'(r2_mag[k] << (TOP_POS - r2_pos));
        end
        r3_sd <= r2_sd;
    end

    // stage 4: squares
    logic                    r4_v;
    logic [2*MAG_W-1:0]      r4_sq [3];
    logic [2:0][MAG_W-1:0]   r4_m;
    t_side                   r4_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        for (int k = 0; k < 3; k++) begin
            r4_sq[k] <= (2*MAG_W)'(r3_m[k]) * (2*MAG_W)'(r3_m[k]);
        end
        r4_m  <= r3_m;
        r4_sd <= r3_sd;
    end

    // stage 5: sum of squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r4_v;
        o_sum       <= SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
        o_side.mag  <= r4_m;
        o_side.sd   <= r4_sd;
    end

endmodule

### rtl/tlrg_isqrt.sv
// ----------------------------------------------------------------------------
// tlrg_isqrt
// Floor integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tlrg_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tlrg_pkg::SQ_W-1:0]     i_x,
    input  tlrg_pkg::t_nside              i_side,
    output logic                          o_valid,
    output logic [tlrg_pkg::ROOT_W-1:0]   o_root,
    output tlrg_pkg::t_nside              o_side
);
    import tlrg_pkg::*;

    localparam int RW = SQ_W + 1;

    logic [RW-1:0]     r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_q    [ROOT_W];
    logic              r_v    [ROOT_W];
    t_nside            r_side [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int B = ROOT_W - 1 - g;
        logic [RW-1:0]     rem_in;
        logic [ROOT_W-1:0] q_in;
        logic              v_in;
        t_nside            side_in;
        logic [RW-1:0]     trial;

        if (g == 0) begin : g_first
            assign rem_in  = RW'(i_x);
            assign q_in    = '0;
            assign v_in    = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign q_in    = r_q[g-1];
            assign v_in    = r_v[g-1];
            assign side_in = r_side[g-1];
        end

        // try the next root bit
        assign trial = (RW'(q_in) << (B + 1)) + (RW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[g] <= 1'b0;
            else          r_v[g] <= v_in;
            if (rem_in >= trial) begin
                r_rem[g] <= rem_in - trial;
                r_q[g]   <= q_in | (ROOT_W'(1) << B);
            end else begin
                r_rem[g] <= rem_in;
                r_q[g]   <= q_in;
            end
            r_side[g] <= side_in;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_q[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

### rtl/tlrg_div.sv
// ----------------------------------------------------------------------------
// tlrg_div
// Rounded quotient of each magnitude over the length, restoring division
// with one quotient bit per register stage and three lanes.
// ----------------------------------------------------------------------------
module tlrg_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [tlrg_pkg::ROOT_W-1:0]       i_len,
    input  tlrg_pkg::t_nside                  i_side,
    output logic                              o_valid,
    output logic [2:0][tlrg_pkg::QUO_W-1:0]   o_quo,
    output tlrg_pkg::t_side                   o_side
);
    import tlrg_pkg::*;

    logic [2:0][NUM_W-1:0] r_rem  [QUO_W];
    logic [2:0][QUO_W-1:0] r_q    [QUO_W];
    logic [ROOT_W-1:0]     r_len  [QUO_W];
    logic                  r_v    [QUO_W];
    t_side                 r_side [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int B = QUO_W - 1 - g;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] q_in;
        logic [ROOT_W-1:0]     len_in;
        logic                  v_in;
        t_side                 side_in;
        logic [NUM_W-1:0]      dsh;

        if (g == 0) begin : g_first
            // numerator: magnitude in q.14 plus half the length
            for (genvar k = 0; k < 3; k++) begin : g_num
                assign rem_in[k] = (NUM_W'(i_side.mag[k]) << 14) + NUM_W'(i_len >> 1);
            end
            assign q_in    = '0;
            assign len_in  = i_len;
            assign v_in    = i_valid;
            assign side_in = i_side.sd;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign q_in    = r_q[g-1];
            assign len_in  = r_len[g-1];
            assign v_in    = r_v[g-1];
            assign side_in = r_side[g-1];
        end

        assign dsh = NUM_W'(len_in) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[g] <= 1'b0;
            else          r_v[g] <= v_in;
            for (int k = 0; k < 3; k++) begin
                if (rem_in[k] >= dsh) begin
                    r_rem[g][k] <= rem_in[k] - dsh;
                    r_q[g][k]   <= q_in[k] | (QUO_W'(1) << B);
                end else begin
                    r_rem[g][k] <= rem_in[k];
                    r_q[g][k]   <= q_in[k];
                end
            end
            r_len[g]  <= len_in;
            r_side[g] <= side_in;
        end
    end

    assign o_valid = r_v[QUO_W-1];
    assign o_quo   = r_q[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

### rtl/thin_lens_ray_generator.sv
// ----------------------------------------------------------------------------
// thin_lens_ray_generator
// Thin-lens camera primary ray generator: saturated q11.8 origin and unit
// q1.14 direction for each pixel sample, one ray per clock.
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  request   start, busy, i_col .. i_disk_y           in
//  ray       o_done, o_origin_x .. o_dir_z            out
//  config    psel, penable, pwrite, paddr, pwdata,    in/out
//            prdata, pready (64-bit registers, 8*i)
//
//  one word is taken every cycle; busy is never raised
//  a ray passes through 6 front stages, 5 normalize
//  stages, 31 square-root stages, 15 divide stages and the output register
//  reset clears all valid bits and loads the register reset values
//  o_done is high for one cycle per ray and cannot be held off
// ----------------------------------------------------------------------------
module thin_lens_ray_generator #(
    parameter int COORD_BITS = tlrg_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             i_col,
    input  logic [COORD_BITS-1:0]             i_row,
    input  logic [tlrg_pkg::SMP_W-1:0]        i_sample_x,
    input  logic [tlrg_pkg::SMP_W-1:0]        i_sample_y,
    input  logic signed [tlrg_pkg::DSK_W-1:0] i_disk_x,
    input  logic signed [tlrg_pkg::DSK_W-1:0] i_disk_y,
    // ray
    output logic                              o_done,
    output logic signed [tlrg_pkg::ORG_W-1:0] o_origin_x,
    output logic signed [tlrg_pkg::ORG_W-1:0] o_origin_y,
    output logic signed [tlrg_pkg::ORG_W-1:0] o_origin_z,
    output logic signed [tlrg_pkg::DIR_W-1:0] o_dir_x,
    output logic signed [tlrg_pkg::DIR_W-1:0] o_dir_y,
    output logic signed [tlrg_pkg::DIR_W-1:0] o_dir_z,
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlrg_pkg::CFG_AW-1:0]       paddr,
    input  logic [tlrg_pkg::CFG_DW-1:0]       pwdata,
    output logic [tlrg_pkg::CFG_DW-1:0]       prdata,
    output logic                              pready
);
    import tlrg_pkg::*;

    localparam int DW = dir_width(COORD_BITS);

    // configuration registers
    logic [BASIS_W-1:0] r_basis_u, r_basis_v, r_basis_w;
    logic [EYE_W-1:0]   r_eye;
    logic [RAD_W-1:0]   r_lens_radius;
    logic [PSC_W-1:0]   r_plane_scale;
    logic [FOC_W-1:0]   r_focal_dist;
    logic [ISZ_W-1:0]   r_image_size;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_AW-1:CFG_AW-CFG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_u     <= RST_BASIS_U;
            r_basis_v     <= RST_BASIS_V;
            r_basis_w     <= RST_BASIS_W;
            r_eye         <= RST_EYE;
            r_lens_radius <= RST_RAD;
            r_plane_scale <= RST_PSC;
            r_focal_dist  <= RST_FOC;
            r_image_size  <= RST_ISZ;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BASIS_U:   r_basis_u     <= pwdata[BASIS_W-1:0];
                REG_BASIS_V:   r_basis_v     <= pwdata[BASIS_W-1:0];
                REG_BASIS_W:   r_basis_w     <= pwdata[BASIS_W-1:0];
                REG_EYE:       r_eye         <= pwdata[EYE_W-1:0];
                REG_LENS_RAD:  r_lens_radius <= pwdata[RAD_W-1:0];
                REG_PLANE_SCL: r_plane_scale <= pwdata[PSC_W-1:0];
                REG_FOCAL:     r_focal_dist  <= pwdata[FOC_W-1:0];
                REG_IMG_SIZE:  r_image_size  <= pwdata[ISZ_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_BASIS_U:   prdata = CFG_DW'(r_basis_u);
            REG_BASIS_V:   prdata = CFG_DW'(r_basis_v);
            REG_BASIS_W:   prdata = CFG_DW'(r_basis_w);
            REG_EYE:       prdata = CFG_DW'(r_eye);
            REG_LENS_RAD:  prdata = CFG_DW'(r_lens_radius);
            REG_PLANE_SCL: prdata = CFG_DW'(r_plane_scale);
            REG_FOCAL:     prdata = CFG_DW'(r_focal_dist);
            REG_IMG_SIZE:  prdata = CFG_DW'(r_image_size);
            default:       prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    // origin and unnormalized direction
    logic                  f_valid;
    logic [2:0][ORG_W-1:0] f_org;
    logic [2:0][DW-1:0]    f_mag;
    logic [2:0]            f_neg;

    tlrg_front #(
        .COORD_BITS (COORD_BITS),
        .DW         (DW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start && !busy),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_disk_x      (i_disk_x),
        .i_disk_y      (i_disk_y),
        .i_basis_u     (r_basis_u),
        .i_basis_v     (r_basis_v),
        .i_basis_w     (r_basis_w),
        .i_eye         (r_eye),
        .i_lens_radius (r_lens_radius),
        .i_plane_scale (r_plane_scale),
        .i_focal_dist  (r_focal_dist),
        .i_image_size  (r_image_size),
        .o_valid       (f_valid),
        .o_org         (f_org),
        .o_mag         (f_mag),
        .o_neg         (f_neg)
    );

    // normalize and sum of squares
    logic              n_valid;
    logic [SQ_W-1:0]   n_sum;
    t_nside            n_side;

    tlrg_norm #(
        .DW (DW)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_mag   (f_mag),
        .i_neg   (f_neg),
        .i_org   (f_org),
        .o_valid (n_valid),
        .o_sum   (n_sum),
        .o_side  (n_side)
    );

    // length
    logic              s_valid;
    logic [ROOT_W-1:0] s_root;
    t_nside            s_side;

    tlrg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_valid),
        .i_x     (n_sum),
        .i_side  (n_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // unit components
    logic                  d_valid;
    logic [2:0][QUO_W-1:0] d_quo;
    t_side                 d_side;

    tlrg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_len   (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // clamp, restore sign and register the ray
    logic [2:0][DIR_W-1:0] dir;
    logic [QUO_W-1:0]      qc;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qc = (d_quo[k] > Q_ONE) ? Q_ONE : d_quo[k];
            if (d_side.zero)        dir[k] = '0;
            else if (d_side.neg[k]) dir[k] = -DIR_W'(qc);
            else                    dir[k] = DIR_W'(qc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= d_valid;
        o_origin_x <= d_side.org[0];
        o_origin_y <= d_side.org[1];
        o_origin_z <= d_side.org[2];
        o_dir_x    <= dir[0];
        o_dir_y    <= dir[1];
        o_dir_z    <= dir[2];
    end

endmodule

### sim/thin_lens_ray_generator_check.sv
// ----------------------------------------------------------------------------
// thin_lens_ray_generator_check
// Watches the request, ray and config channels of the ray generator, keeps
// its own copy of the camera registers, predicts each ray and compares the
// rays that come out, in order, field by field.
// ----------------------------------------------------------------------------
module thin_lens_ray_generator_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [11:0]                        i_col,
    input  logic [11:0]                        i_row,
    input  logic [tlrg_pkg::SMP_W-1:0]         i_sample_x,
    input  logic [tlrg_pkg::SMP_W-1:0]         i_sample_y,
    input  logic signed [tlrg_pkg::DSK_W-1:0]  i_disk_x,
    input  logic signed [tlrg_pkg::DSK_W-1:0]  i_disk_y,
    input  logic                               o_done,
    input  logic signed [tlrg_pkg::ORG_W-1:0]  o_origin_x,
    input  logic signed [tlrg_pkg::ORG_W-1:0]  o_origin_y,
    input  logic signed [tlrg_pkg::ORG_W-1:0]  o_origin_z,
    input  logic signed [tlrg_pkg::DIR_W-1:0]  o_dir_x,
    input  logic signed [tlrg_pkg::DIR_W-1:0]  o_dir_y,
    input  logic signed [tlrg_pkg::DIR_W-1:0]  o_dir_z,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlrg_pkg::CFG_AW-1:0]        paddr,
    input  logic [tlrg_pkg::CFG_DW-1:0]        pwdata,
    input  logic                               pready,
    output int                                 o_fails,
    output int                                 o_pending
);
    import tlrg_pkg::*;

    typedef struct {
        logic signed [ORG_W-1:0] org [3];
        logic signed [DIR_W-1:0] dir [3];
    } t_ray;

    // camera registers as the block should hold them
    logic [BASIS_W-1:0] cam_u, cam_v, cam_w;
    logic [EYE_W-1:0]   cam_eye;
    logic [RAD_W-1:0]   cam_rad;
    logic [PSC_W-1:0]   cam_psc;
    logic [FOC_W-1:0]   cam_foc;
    logic [ISZ_W-1:0]   cam_isz;

    t_ray rays_due [$];

    initial begin
        o_fails = 0;
        cam_u = RST_BASIS_U; cam_v = RST_BASIS_V; cam_w = RST_BASIS_W;
        cam_eye = RST_EYE; cam_rad = RST_RAD; cam_psc = RST_PSC;
        cam_foc = RST_FOC; cam_isz = RST_ISZ;
    end

    assign o_pending = rays_due.size();

    function automatic longint rshift_round(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // thin-lens ray for one pixel sample under the current registers
    function automatic t_ray trace_ray(logic [11:0] col, logic [11:0] row,
                                       logic [15:0] sx, logic [15:0] sy,
                                       logic signed [15:0] dx,
                                       logic signed [15:0] dy);
        t_ray r;
        longint cx, cy, px, py, lx, ly, ax, ay, f16, uk, vk, wk, e, o, d;
        longint unsigned mag [3];
        longint unsigned mx, len, q;
        bit neg [3];
        cx = longint'(col) * 65536 - longint'(cam_isz[11:0]) * 32768 + longint'(sx);
        cy = longint'(row) * 65536 - longint'(cam_isz[23:12]) * 32768 + longint'(sy);
        px = rshift_round(longint'(cam_psc) * cx, 12);
        py = rshift_round(longint'(cam_psc) * cy, 12);
        lx = rshift_round(longint'(dx) * longint'(cam_rad), 6);
        ly = rshift_round(longint'(dy) * longint'(cam_rad), 6);
        f16 = longint'(cam_foc) * 256;
        ax = px - lx;
        ay = py - ly;
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            uk = longint'($signed(cam_u[16*k +: 16]));
            vk = longint'($signed(cam_v[16*k +: 16]));
            wk = longint'($signed(cam_w[16*k +: 16]));
            e  = longint'($signed(cam_eye[20*k +: 20]));
            o  = rshift_round(e * 4194304 + lx * uk + ly * vk, 22);
            if (o > 524287) o = 524287;
            if (o < -524288) o = -524288;
            r.org[k] = o[ORG_W-1:0];
            d = ax * uk + ay * vk - f16 * wk;
            neg[k] = d < 0;
            mag[k] = neg[k] ? -d : d;
            if (mag[k] > mx) mx = mag[k];
        end
        // zero direction gives an all-zero direction
        if (mx == 0) begin
            for (int k = 0; k < 3; k++) r.dir[k] = '0;
            return r;
        end
        // bring the largest magnitude into [2^29, 2^30)
        while (mx >= (longint'(1) << 30)) begin
            mx >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        while (mx < (longint'(1) << 29)) begin
            mx <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        len = floor_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << 14) + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            r.dir[k] = neg[k] ? -q[15:0] : q[15:0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fails++;
    endtask

    // register writes
    always @(posedge i_clk) begin
        if (i_rst_n && psel && penable && pwrite && pready) begin
            case (paddr[5:3])
                REG_BASIS_U:   cam_u   = pwdata[BASIS_W-1:0];
                REG_BASIS_V:   cam_v   = pwdata[BASIS_W-1:0];
                REG_BASIS_W:   cam_w   = pwdata[BASIS_W-1:0];
                REG_EYE:       cam_eye = pwdata[EYE_W-1:0];
                REG_LENS_RAD:  cam_rad = pwdata[RAD_W-1:0];
                REG_PLANE_SCL: cam_psc = pwdata[PSC_W-1:0];
                REG_FOCAL:     cam_foc = pwdata[FOC_W-1:0];
                REG_IMG_SIZE:  cam_isz = pwdata[ISZ_W-1:0];
                default: ;
            endcase
        end
    end

    // accepted words and finished rays
    always @(posedge i_clk) begin
        t_ray want;
        logic signed [ORG_W-1:0] go [3];
        logic signed [DIR_W-1:0] gd [3];
        if (i_rst_n) begin
            if (start && !busy)
                rays_due.push_back(trace_ray(i_col, i_row, i_sample_x, i_sample_y,
                                             i_disk_x, i_disk_y));
            if (o_done) begin
                if (rays_due.size() == 0) begin
                    flag_mismatch("unexpected ray", 1, 0);
                end else begin
                    want = rays_due.pop_front();
                    go = '{o_origin_x, o_origin_y, o_origin_z};
                    gd = '{o_dir_x, o_dir_y, o_dir_z};
                    for (int k = 0; k < 3; k++) begin
                        if (go[k] !== want.org[k])
                            flag_mismatch($sformatf("origin[%0d]", k), go[k], want.org[k]);
                        if (gd[k] !== want.dir[k])
                            flag_mismatch($sformatf("dir[%0d]", k), gd[k], want.dir[k]);
                    end
                end
            end
        end
    end

endmodule

### sim/thin_lens_ray_generator_test.sv
// ----------------------------------------------------------------------------
// thin_lens_ray_generator_test
// Drives pixel sample words and camera register writes into the ray
// generator: a directed part for corner cases, then random phases with
// varied registers and sender gaps. The checker predicts and compares.
// ----------------------------------------------------------------------------
module thin_lens_ray_generator_test;
    import tlrg_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic [11:0] i_col = 0, i_row = 0;
    logic [SMP_W-1:0] i_sample_x = 0, i_sample_y = 0;
    logic signed [DSK_W-1:0] i_disk_x = 0, i_disk_y = 0;
    logic o_done;
    logic signed [ORG_W-1:0] o_origin_x, o_origin_y, o_origin_z;
    logic signed [DIR_W-1:0] o_dir_x, o_dir_y, o_dir_z;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [CFG_AW-1:0] paddr = 0;
    logic [CFG_DW-1:0] pwdata = 0;
    logic [CFG_DW-1:0] prdata;
    logic pready;
    int fails, pending;
    int gap_pct;

    always #2 i_clk = ~i_clk;

    thin_lens_ray_generator dut (.*);
    thin_lens_ray_generator_check checker_i (.*, .o_fails(fails), .o_pending(pending));

    // one register write: setup then access
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {idx, 3'b000}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // hold the next word until taken, idle cycles drawn one at a time first
    task automatic send_word(logic [11:0] col, logic [11:0] row, logic [15:0] sx,
                             logic [15:0] sy, logic signed [15:0] dx,
                             logic signed [15:0] dy);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            start = 0;
            @(negedge i_clk);
        end
        start = 1;
        i_col = col; i_row = row; i_sample_x = sx; i_sample_y = sy;
        i_disk_x = dx; i_disk_y = dy;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain;
        @(negedge i_clk);
        start = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rnd_disk;
        case ($urandom_range(3))
            0: return 16'sd16384;
            1: return -16'sd16384;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] rnd64;
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [CFG_DW-1:0] bu, bv, bw;
        gap_pct = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // reset registers: extremes of the pixel and sample fields
        send_word(0, 0, 0, 0, 0, 0);
        send_word(12'hfff, 12'hfff, 16'hffff, 16'hffff, 16'sd16384, -16'sd16384);
        send_word(12'h800, 12'h7ff, 16'h8000, 16'h0001, -16'sd16384, 16'sd16384);
        send_word(1, 2, 16'h5555, 16'haaaa, 16'sd1, -16'sd1);
        drain;

        // odd image size, zero focal distance, eye near the ends of its range
        write_reg(REG_IMG_SIZE, {12'd479, 12'd641});
        write_reg(REG_FOCAL, 0);
        write_reg(REG_EYE, {20'h7ff00, 20'h80010, 20'h7ffff});
        write_reg(REG_LENS_RAD, 19'h7ffff);
        write_reg(REG_PLANE_SCL, 16'hffff);
        write_reg(REG_BASIS_U, {16'h4000, 16'hc000, 16'h4000});
        write_reg(REG_BASIS_V, {16'hc000, 16'h4000, 16'h4000});
        write_reg(REG_BASIS_W, {16'h0000, 16'h0000, 16'h4000});
        send_word(320, 239, 16'h8000, 16'h8000, 0, 0);
        send_word(320, 240, 0, 0, 0, 0);
        send_word(0, 0, 0, 0, 16'sd16384, 16'sd16384);
        send_word(12'hfff, 12'hfff, 16'hffff, 16'hffff, -16'sd16384, -16'sd16384);
        send_word(100, 50, 16'h1234, 16'hfedc, 16'sd11585, -16'sd11585);
        drain;
        // zero lens and plane scale: every direction is zero
        write_reg(REG_LENS_RAD, 0);
        write_reg(REG_PLANE_SCL, 0);
        send_word(7, 9, 16'hffff, 0, 16'sd16384, -16'sd16384);
        send_word(12'hfff, 0, 0, 16'hffff, -16'sd3, 16'sd3);
        drain;

        // random phases: no gaps, heavy gaps, none, lighter gaps
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = (ph == 1) ? 45 : (ph == 3) ? 38 : 0;
            bu = {16'($urandom_range(32768) - 16384), 16'($urandom), 16'h4000};
            bv = rnd64();
            bw = {16'h4000, 16'($urandom_range(8192)), 16'($urandom)};
            write_reg(REG_BASIS_U, ph[0] ? rnd64() : bu);
            write_reg(REG_BASIS_V, bv);
            write_reg(REG_BASIS_W, ph[1] ? rnd64() : bw);
            write_reg(REG_EYE, rnd64());
            write_reg(REG_LENS_RAD, ph == 2 ? 19'h7ffff : 19'($urandom_range(4096)));
            write_reg(REG_PLANE_SCL, ph == 2 ? 16'hffff : 16'($urandom_range(2048)));
            write_reg(REG_FOCAL, ph == 2 ? 19'h7ffff : 19'($urandom));
            write_reg(REG_IMG_SIZE, ph == 2 ? 24'hffffff : 24'($urandom));
            repeat (110)
                send_word(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom),
                          rnd_disk(), rnd_disk());
            drain;
        end

        repeat (80) @(negedge i_clk);
        if (fails == 0 && pending == 0)
            $display("PASS thin_lens_ray_generator");
        else
            $display("FAIL thin_lens_ray_generator");
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL thin_lens_ray_generator");
        $finish;
    end

endmodule

### sim.f
rtl/tlrg_pkg.sv
rtl/tlrg_front.sv
rtl/tlrg_norm.sv
rtl/tlrg_isqrt.sv
rtl/tlrg_div.sv
rtl/thin_lens_ray_generator.sv
sim/thin_lens_ray_generator_check.sv
sim/thin_lens_ray_generator_test.sv
